// ===== rtl/ntrle_pkg.sv =====
// Shared types, constants and the run-length step function of the frame decoder.
package ntrle_pkg;

    localparam int TABLE_ENTRIES = 15;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

    localparam logic [3:0] NIB_ESC  = 4'hF;
    localparam logic [7:0] RUN_BIAS = 8'h7F;

    localparam logic [1:0] MODE_RLE    = 2'd0;
    localparam logic [1:0] MODE_NIBBLE = 2'd1;
    localparam logic [1:0] MODE_BOTH   = 2'd2;

    localparam logic [1:0] NMID_NONE = 2'd0;
    localparam logic [1:0] NMID_ONE  = 2'd1;
    localparam logic [1:0] NMID_TWO  = 2'd2;

    typedef enum logic [1:0] {
        NPH_CODE    = 2'd0,
        NPH_ESC_HI  = 2'd1,
        NPH_LITERAL = 2'd2
    } nib_phase_t;

    typedef enum logic [1:0] {
        RPH_CODE    = 2'd0,
        RPH_REPEAT  = 2'd1,
        RPH_LITERAL = 2'd2
    } run_phase_t;

    typedef struct packed {
        run_phase_t  phase;
        logic [7:0]  lit_rem;
        logic [7:0]  rep_len;
    } run_state_t;

    typedef struct packed {
        logic        produce;
        logic [7:0]  value;
        logic [7:0]  count;
        run_state_t  state;
    } run_result_t;

    // One queue entry: the nibble stage output of one input byte.
    typedef struct packed {
        logic        frame_start;
        logic        use_run;
        logic [1:0]  n_mid;
        logic [7:0]  mid0;
        logic [7:0]  mid1;
    } q_entry_t;

    typedef struct packed {
        logic out_valid;
        logic pend_valid;
    } back_status_t;

    localparam run_state_t RUN_IDLE = '{phase: RPH_CODE, lit_rem: 8'd0, rep_len: 8'd0};

    // Advance the run-length stage by one byte.
    function automatic run_result_t run_step(run_state_t s, logic [7:0] b);
        run_result_t r;
        r.produce = 1'b0;
        r.value   = b;
        r.count   = 8'd1;
        r.state   = s;
        unique case (s.phase)
            RPH_REPEAT:
            begin
                r.produce       = 1'b1;
                r.count         = s.rep_len;
                r.state.phase   = RPH_CODE;
            end
            RPH_LITERAL:
            begin
                r.produce       = 1'b1;
                r.state.lit_rem = s.lit_rem - 8'd1;
                if (r.state.lit_rem == 8'd0)
                begin
                    r.state.phase = RPH_CODE;
                end
            end
            default:
            begin
                if (b[7])
                begin
                    r.state.rep_len = b - RUN_BIAS;
                    r.state.phase   = RPH_REPEAT;
                end
                else
                begin
                    r.state.lit_rem = b + 8'd1;
                    r.state.phase   = RPH_LITERAL;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ntrle_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module ntrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/ntrle_front.sv =====
// Front end: table load, nibble decode and table lookup, one byte per cycle while the queue takes entries.
module ntrle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          decode_mode,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output logic                q_valid,
    input  logic                q_ready,
    output ntrle_pkg::q_entry_t q_data
);

    logic [3:0]              load_cnt_reg, load_cnt_next;
    ntrle_pkg::nib_phase_t   nph_reg, nph_next;
    logic [3:0]              held_reg, held_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    s2_fs_reg;
    logic                    s2_use_run_reg;
    logic [1:0]              s2_n_reg;
    logic                    s2_sel_tbl_reg;
    logic [7:0]              s2_lit0_reg;

    logic                    accept;
    logic [3:0]              cnt_c;
    ntrle_pkg::nib_phase_t   ph_c;
    logic [3:0]              held_c;
    logic [3:0]              hi;
    logic [3:0]              lo;
    logic [1:0]              n_mid;
    logic                    sel_tbl;
    logic [7:0]              lit0;
    logic                    tbl_we;
    logic [7:0]              rdata_a;
    logic [7:0]              rdata_b;

    assign in_ready = !s2_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign hi       = data_byte[7:4];
    assign lo       = data_byte[3:0];

    ntrle_ram #(
        .WIDTH (8),
        .DEPTH (ntrle_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (cnt_c[ntrle_pkg::TBL_AW-1:0]),
        .wdata   (data_byte),
        .re      (accept),
        .raddr_a (hi[ntrle_pkg::TBL_AW-1:0]),
        .raddr_b (lo[ntrle_pkg::TBL_AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        cnt_c   = frame_start ? 4'd0 : load_cnt_reg;
        ph_c    = frame_start ? ntrle_pkg::NPH_CODE : nph_reg;
        held_c  = frame_start ? 4'd0 : held_reg;
        load_cnt_next = load_cnt_reg;
        nph_next      = nph_reg;
        held_next     = held_reg;
        n_mid   = ntrle_pkg::NMID_NONE;
        sel_tbl = 1'b0;
        lit0    = data_byte;
        tbl_we  = 1'b0;
        if (accept)
        begin
            load_cnt_next = cnt_c;
            nph_next      = ph_c;
            held_next     = held_c;
            if (decode_mode == ntrle_pkg::MODE_RLE)
            begin
                n_mid = ntrle_pkg::NMID_ONE;
            end
            else if (cnt_c < 4'(ntrle_pkg::TABLE_ENTRIES))
            begin
                tbl_we        = 1'b1;
                load_cnt_next = cnt_c + 4'd1;
            end
            else
            begin
                unique case (ph_c)
                    ntrle_pkg::NPH_LITERAL:
                    begin
                        nph_next = ntrle_pkg::NPH_CODE;
                        n_mid    = ntrle_pkg::NMID_ONE;
                    end
                    ntrle_pkg::NPH_ESC_HI:
                    begin
                        lit0 = {held_c, hi};
                        if (lo == ntrle_pkg::NIB_ESC)
                        begin
                            nph_next = ntrle_pkg::NPH_LITERAL;
                            n_mid    = ntrle_pkg::NMID_ONE;
                        end
                        else
                        begin
                            nph_next = ntrle_pkg::NPH_CODE;
                            n_mid    = ntrle_pkg::NMID_TWO;
                        end
                    end
                    default:
                    begin
                        if (hi == ntrle_pkg::NIB_ESC)
                        begin
                            held_next = lo;
                            nph_next  = ntrle_pkg::NPH_ESC_HI;
                        end
                        else
                        begin
                            sel_tbl = 1'b1;
                            if (lo == ntrle_pkg::NIB_ESC)
                            begin
                                nph_next = ntrle_pkg::NPH_LITERAL;
                                n_mid    = ntrle_pkg::NMID_ONE;
                            end
                            else
                            begin
                                nph_next = ntrle_pkg::NPH_CODE;
                                n_mid    = ntrle_pkg::NMID_TWO;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Hold the lookup stage until the queue takes it.
    assign s2_valid_next = accept ? 1'b1 : (q_ready ? 1'b0 : s2_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= 4'd0;
            nph_reg      <= ntrle_pkg::NPH_CODE;
            held_reg     <= 4'd0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            nph_reg      <= nph_next;
            held_reg     <= held_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_fs_reg      <= frame_start;
            s2_use_run_reg <= (decode_mode != ntrle_pkg::MODE_NIBBLE);
            s2_n_reg       <= n_mid;
            s2_sel_tbl_reg <= sel_tbl;
            s2_lit0_reg    <= lit0;
        end
    end

    assign q_valid            = s2_valid_reg;
    assign q_data.frame_start = s2_fs_reg;
    assign q_data.use_run     = s2_use_run_reg;
    assign q_data.n_mid       = s2_n_reg;
    assign q_data.mid0        = s2_sel_tbl_reg ? rdata_a : s2_lit0_reg;
    assign q_data.mid1        = rdata_b;

endmodule

// ===== rtl/ntrle_fifo.sv =====
// Short queue of decoded nibble-stage entries between front and back ends.
module ntrle_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ntrle_pkg::q_entry_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ntrle_pkg::q_entry_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ntrle_pkg::q_entry_t mem_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/ntrle_back.sv =====
// Back end: run-length stage over up to two bytes and a two-slot result buffer.
module ntrle_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  ntrle_pkg::q_entry_t     q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              pixel_value,
    output logic [7:0]              repeat_count,
    output logic                    last_of_run,
    output ntrle_pkg::back_status_t status
);

    ntrle_pkg::run_state_t  run_reg, run_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [7:0]             out_val_reg, out_val_next;
    logic [7:0]             out_cnt_reg, out_cnt_next;
    logic                   out_last_reg, out_last_next;
    logic [7:0]             pend_val_reg, pend_val_next;
    logic [7:0]             pend_cnt_reg, pend_cnt_next;

    ntrle_pkg::run_state_t  s0;
    ntrle_pkg::run_state_t  s1;
    ntrle_pkg::run_state_t  s_end;
    ntrle_pkg::run_result_t r0;
    ntrle_pkg::run_result_t r1;
    logic                   has0;
    logic                   has1;
    logic                   p0;
    logic                   p1;
    logic [7:0]             v0, c0, v1, c1;
    logic [7:0]             first_val, first_cnt;
    logic                   can_take;
    logic                   pop;

    assign can_take = !out_valid_reg || (m_ready && !pend_valid_reg);
    assign q_ready  = can_take;
    assign pop      = q_valid && can_take;

    always_comb
    begin
        has0  = (q_data.n_mid != ntrle_pkg::NMID_NONE);
        has1  = (q_data.n_mid == ntrle_pkg::NMID_TWO);
        s0    = q_data.frame_start ? ntrle_pkg::RUN_IDLE : run_reg;
        r0    = ntrle_pkg::run_step(s0, q_data.mid0);
        s1    = has0 ? r0.state : s0;
        r1    = ntrle_pkg::run_step(s1, q_data.mid1);
        if (q_data.use_run)
        begin
            s_end = has1 ? r1.state : s1;
            p0    = has0 && r0.produce;
            p1    = has1 && r1.produce;
            v0    = r0.value;
            c0    = r0.count;
            v1    = r1.value;
            c1    = r1.count;
        end
        else
        begin
            s_end = s0;
            p0    = has0;
            p1    = has1;
            v0    = q_data.mid0;
            c0    = 8'd1;
            v1    = q_data.mid1;
            c1    = 8'd1;
        end
        first_val = p0 ? v0 : v1;
        first_cnt = p0 ? c0 : c1;
    end

    always_comb
    begin
        run_next        = run_reg;
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_val_next    = out_val_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        pend_val_next   = pend_val_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (pop)
        begin
            run_next        = s_end;
            out_valid_next  = p0 || p1;
            out_val_next    = first_val;
            out_cnt_next    = first_cnt;
            out_last_next   = !(p0 && p1);
            pend_valid_next = p0 && p1;
            pend_val_next   = v1;
            pend_cnt_next   = c1;
        end
        else if (out_valid_reg && m_ready)
        begin
            // Advance the second result of a pair into the output slot.
            out_valid_next  = pend_valid_reg;
            out_val_next    = pend_val_reg;
            out_cnt_next    = pend_cnt_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= ntrle_pkg::RUN_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg        <= run_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        pend_val_reg <= pend_val_next;
        pend_cnt_reg <= pend_cnt_next;
    end

    assign m_valid           = out_valid_reg;
    assign pixel_value       = out_val_reg;
    assign repeat_count      = out_cnt_reg;
    assign last_of_run       = out_last_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.pend_valid = pend_valid_reg;

endmodule

// ===== rtl/nibble_table_rle_frame_decoder.sv =====
// Path: a byte passes the lookup stage register, the queue and the back end's output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
// ready; a byte that yields two results holds the back end while its second result waits in the result pair buffer.
// Reset: decode_mode, table load count, nibble and run state and the queue clear
// at once; the symbol table keeps its contents and is reloaded after each frame start in the nibble modes.
// Top level of the nibble-table / run-length frame decoder.
module nibble_table_rle_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,     // decode_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [7:0] pixel_value, [15:8] repeat_count
    output logic        m_axis_tlast     // last_of_run
);

    logic [1:0]              decode_mode_reg;
    logic                    fq_valid;
    logic                    fq_ready;
    ntrle_pkg::q_entry_t     fq_data;
    logic                    qb_valid;
    logic                    qb_ready;
    ntrle_pkg::q_entry_t     qb_data;
    ntrle_pkg::back_status_t bk_status;
    logic [7:0]              pixel_value;
    logic [7:0]              repeat_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= ntrle_pkg::MODE_RLE;
        end
        else if (cfg_wr_en)
        begin
            decode_mode_reg <= cfg_wr_data;
        end
    end

    ntrle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .decode_mode (decode_mode_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    ntrle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    ntrle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .last_of_run  (m_axis_tlast),
        .status       (bk_status)
    );

    assign m_axis_tdata = {repeat_count, pixel_value};

    a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.pend_valid |-> m_axis_tvalid)
        else $error("second result buffered without a first result on the output");

    a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && bk_status.pend_valid) |-> !m_axis_tlast)
        else $error("first result of a pair flagged as last");

    a_queue_count_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !qb_valid |-> fq_ready)
        else $error("queue reports empty and full at once");

    a_front_holds_request: assert property (@(posedge clk) disable iff (!rst_n)
        (fq_valid && !fq_ready) |=> fq_valid)
        else $error("front end dropped a request the queue did not take");

endmodule
